// ===== rtl/wsdu_pkg.sv =====
`default_nettype none

package wsdu_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 4;
  localparam int unsigned LenW    = 63;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned ShortW  = 7;

  // Packed stream widths: tdata = {pad, payload_length, payload_byte}
  localparam int unsigned TdataW  = 72;
  localparam int unsigned TuserW  = 6;

  // Short length codes that announce an extended length
  localparam logic [ShortW-1:0] LEN_CODE_16 = 7'd126;
  localparam logic [ShortW-1:0] LEN_CODE_64 = 7'd127;

  // Parser phase: header bytes, extended length bytes, key bytes, payload
  typedef enum logic [3:0] {
    PH_B0     = 4'd0,
    PH_B1     = 4'd1,
    PH_E16_0  = 4'd2,
    PH_E16_1  = 4'd3,
    PH_E64_0  = 4'd4,
    PH_E64_1  = 4'd5,
    PH_E64_2  = 4'd6,
    PH_E64_3  = 4'd7,
    PH_E64_4  = 4'd8,
    PH_E64_5  = 4'd9,
    PH_E64_6  = 4'd10,
    PH_E64_7  = 4'd11,
    PH_KEY    = 4'd12,
    PH_DATA   = 4'd13
  } phase_e;

endpackage : wsdu_pkg

`default_nettype wire

// ===== rtl/websocket_frame_deframer_unmasker_top.sv =====
// WebSocket frame deframer and unmasker.
// Slave stream: one raw frame byte per beat on s_axis_tdata_i. Frames follow
// each other with no gap; the byte after the last payload byte opens the next
// frame header. Header bytes (opcode, mask bit and length, extended length,
// mask key) produce no output beat, except the empty-frame beat noted below.
// Master stream: one beat per payload byte, unmasked with the frame key, with
// the opcode, mask flag and decoded length alongside and tlast on the final
// byte of the frame. A frame with an empty payload gives a single beat with
// data_valid low, a zero byte and tlast high.
// Each beat is registered and leaves in the cycle after its byte is taken.
// Throughput: one byte per cycle; the parser state and the output register
// both update on each accepted byte, so the slave side stays ready as long as
// the output register is empty or is being drained in the same cycle.
// Receiver stall: the output register holds its beat and s_axis_tready_o
// drops until the beat is taken; no byte is lost.
// Reset: rst_ni clears the parser to expect a first header byte and empties
// the output register.
`default_nettype none

module websocket_frame_deframer_unmasker_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [7:0] data_byte
  input  wire logic [wsdu_pkg::ByteW-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [7:0] payload_byte, [70:8] payload_length, [71] zero pad
  output logic [wsdu_pkg::TdataW-1:0]        m_axis_tdata_o,
  // [0] data_valid, [4:1] opcode, [5] was_masked
  output logic [wsdu_pkg::TuserW-1:0]        m_axis_tuser_o,
  // last_of_frame
  output logic                               m_axis_tlast_o
);

  // Parser state
  wsdu_pkg::phase_e                 phase_q, phase_d;
  logic [wsdu_pkg::OpW-1:0]         opcode_q, opcode_d;
  logic                             masked_q, masked_d;
  logic [wsdu_pkg::LenW-1:0]        len_q, len_d;
  logic [wsdu_pkg::KeyW-1:0]        key_q, key_d;
  logic [wsdu_pkg::LenW-1:0]        remain_q, remain_d;
  logic [1:0]                       key_idx_q, key_idx_d;

  // Output register
  logic                             out_valid_q;
  logic [wsdu_pkg::ByteW-1:0]       out_byte_q;
  logic                             out_dvalid_q;
  logic [wsdu_pkg::OpW-1:0]         out_op_q;
  logic                             out_masked_q;
  logic [wsdu_pkg::LenW-1:0]        out_len_q;
  logic                             out_last_q;

  // Per-byte decode
  logic                             in_beat;
  logic [wsdu_pkg::ByteW-1:0]       b;
  logic [wsdu_pkg::ShortW-1:0]      short_len;
  logic [wsdu_pkg::LenW-1:0]        len_shift;
  logic [1:0]                       key_sel;
  logic [wsdu_pkg::ByteW-1:0]       key_byte;
  logic                             emit;
  logic [wsdu_pkg::ByteW-1:0]       emit_byte;
  logic                             emit_dvalid;
  logic                             emit_last;

  assign b          = s_axis_tdata_i;
  assign short_len  = b[wsdu_pkg::ShortW-1:0];
  assign len_shift  = {len_q[wsdu_pkg::LenW-1-wsdu_pkg::ByteW:0], b};
  assign key_sel    = ~key_idx_q;
  assign key_byte   = key_q[{key_sel, 3'b000} +: wsdu_pkg::ByteW];

  // Take a byte when the output register is empty or drains this cycle
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      wsdu_pkg::PH_B1: begin
        if (short_len == wsdu_pkg::LEN_CODE_16) begin
          phase_d = wsdu_pkg::PH_E16_0;
        end else if (short_len == wsdu_pkg::LEN_CODE_64) begin
          phase_d = wsdu_pkg::PH_E64_0;
        end else if (b[7]) begin
          phase_d = wsdu_pkg::PH_KEY;
        end else if (short_len == '0) begin
          phase_d = wsdu_pkg::PH_B0;
        end else begin
          phase_d = wsdu_pkg::PH_DATA;
        end
      end
      wsdu_pkg::PH_E16_0, wsdu_pkg::PH_E64_0, wsdu_pkg::PH_E64_1, wsdu_pkg::PH_E64_2,
      wsdu_pkg::PH_E64_3, wsdu_pkg::PH_E64_4, wsdu_pkg::PH_E64_5,
      wsdu_pkg::PH_E64_6: begin
        phase_d = wsdu_pkg::phase_e'(4'(phase_q + 4'd1));
      end
      wsdu_pkg::PH_E16_1, wsdu_pkg::PH_E64_7: begin
        if (masked_q) begin
          phase_d = wsdu_pkg::PH_KEY;
        end else if (len_shift == '0) begin
          phase_d = wsdu_pkg::PH_B0;
        end else begin
          phase_d = wsdu_pkg::PH_DATA;
        end
      end
      wsdu_pkg::PH_KEY: begin
        if (key_idx_q == 2'd3) begin
          phase_d = (len_q == '0) ? wsdu_pkg::PH_B0 : wsdu_pkg::PH_DATA;
        end
      end
      wsdu_pkg::PH_DATA: begin
        if (remain_d == '0) begin
          phase_d = wsdu_pkg::PH_B0;
        end
      end
      // First header byte, and the unused phase codes
      default: begin
        phase_d = wsdu_pkg::PH_B1;
      end
    endcase
  end

  // Datapath and result decode
  always_comb begin
    opcode_d    = opcode_q;
    masked_d    = masked_q;
    len_d       = len_q;
    key_d       = key_q;
    remain_d    = remain_q;
    key_idx_d   = key_idx_q;
    emit        = 1'b0;
    emit_byte   = '0;
    emit_dvalid = 1'b0;
    emit_last   = 1'b1;
    unique case (phase_q)
      wsdu_pkg::PH_B1: begin
        masked_d = b[7];
        len_d    = '0;
        if (short_len != wsdu_pkg::LEN_CODE_16 && short_len != wsdu_pkg::LEN_CODE_64) begin
          len_d     = wsdu_pkg::LenW'(short_len);
          key_idx_d = 2'd0;
          remain_d  = wsdu_pkg::LenW'(short_len);
          emit      = !b[7] && (short_len == '0);
        end
      end
      wsdu_pkg::PH_E16_0, wsdu_pkg::PH_E64_0, wsdu_pkg::PH_E64_1, wsdu_pkg::PH_E64_2,
      wsdu_pkg::PH_E64_3, wsdu_pkg::PH_E64_4, wsdu_pkg::PH_E64_5,
      wsdu_pkg::PH_E64_6: begin
        len_d = len_shift;
      end
      wsdu_pkg::PH_E16_1, wsdu_pkg::PH_E64_7: begin
        len_d     = len_shift;
        key_idx_d = 2'd0;
        remain_d  = len_shift;
        emit      = !masked_q && (len_shift == '0);
      end
      wsdu_pkg::PH_KEY: begin
        key_d     = {key_q[wsdu_pkg::KeyW-1-wsdu_pkg::ByteW:0], b};
        key_idx_d = key_idx_q + 2'd1;
        remain_d  = len_q;
        emit      = (key_idx_q == 2'd3) && (len_q == '0);
      end
      wsdu_pkg::PH_DATA: begin
        key_idx_d   = key_idx_q + 2'd1;
        remain_d    = remain_q - wsdu_pkg::LenW'(1);
        emit        = 1'b1;
        emit_dvalid = 1'b1;
        emit_byte   = masked_q ? (b ^ key_byte) : b;
        emit_last   = (remain_d == '0);
      end
      default: begin
        opcode_d = b[wsdu_pkg::OpW-1:0];
      end
    endcase
  end

  // Advance the parser on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wsdu_pkg::PH_B0;
      opcode_q  <= '0;
      masked_q  <= 1'b0;
      len_q     <= '0;
      key_q     <= '0;
      remain_q  <= '0;
      key_idx_q <= '0;
    end else if (in_beat) begin
      phase_q   <= phase_d;
      opcode_q  <= opcode_d;
      masked_q  <= masked_d;
      len_q     <= len_d;
      key_q     <= key_d;
      remain_q  <= remain_d;
      key_idx_q <= key_idx_d;
    end
  end

  // Output valid: load on an emitting byte, drop when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (in_beat && emit) begin
      out_byte_q   <= emit_byte;
      out_dvalid_q <= emit_dvalid;
      out_op_q     <= opcode_d;
      out_masked_q <= masked_d;
      out_len_q    <= len_d;
      out_last_q   <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_len_q, out_byte_q};
  assign m_axis_tuser_o  = {out_masked_q, out_op_q, out_dvalid_q};
  assign m_axis_tlast_o  = out_last_q;

  // An empty-frame report carries a zero byte and closes the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tlast_o && m_axis_tdata_o[7:0] == '0))
    else $error("empty-frame report without tlast or with data");

  // While in the payload phase at least one byte is still owed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wsdu_pkg::PH_DATA) |-> (remain_q != '0))
    else $error("payload phase with zero remaining bytes");

  // The last payload byte returns the parser to the first header byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && phase_q == wsdu_pkg::PH_DATA && remain_q == wsdu_pkg::LenW'(1))
      |=> (phase_q == wsdu_pkg::PH_B0 && m_axis_tvalid_o && m_axis_tlast_o))
    else $error("frame end not followed by a new header");

  // Key capture always starts at key byte zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wsdu_pkg::PH_KEY && $past(phase_q) != wsdu_pkg::PH_KEY) |-> (key_idx_q == 2'd0))
    else $error("key capture entered with nonzero key index");

endmodule : websocket_frame_deframer_unmasker_top

`default_nettype wire

// ===== verif/websocket_frame_deframer_unmasker_top_test.sv =====
`default_nettype none

module websocket_frame_deframer_unmasker_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wsdu_pkg::*;

  // Frame length encodings used by the stream builder
  localparam int ENC_SHORT = 0;
  localparam int ENC_EXT16 = 1;
  localparam int ENC_EXT64 = 2;

  // Queue entry that makes the sender wait for every pending beat
  localparam int DRAIN_MARK = -1;

  localparam int STREAM_BYTES  = 420;
  localparam int HOLD_AT_BYTE  = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 4000;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [ByteW-1:0] pbyte;
    logic             dvalid;
    logic [OpW-1:0]   op;
    logic             masked;
    logic [LenW-1:0]  plen;
    logic             last;
  } frame_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [ByteW-1:0]  s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [TdataW-1:0] m_tdata;
  logic [TuserW-1:0] m_tuser;
  logic              m_tlast;

  websocket_frame_deframer_unmasker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [7:0] data_byte
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [7:0] payload_byte, [70:8] payload_length, [71] pad
    .m_axis_tuser_o  (m_tuser),   // [0] data_valid, [4:1] opcode, [5] was_masked
    .m_axis_tlast_o  (m_tlast)
  );

  // Stream bytes waiting to be sent, and unmasked beats waiting to arrive
  int          stream_bytes_q[$];
  frame_beat_t unmasked_beats_q[$];

  // Parser state mirrored by the predictor
  phase_e          ws_phase  = PH_B0;
  logic [OpW-1:0]  ws_op     = '0;
  logic            ws_masked = 1'b0;
  logic [LenW-1:0] ws_len    = '0;
  logic [KeyW-1:0] ws_key    = '0;
  logic [LenW-1:0] ws_remain = '0;
  logic [1:0]      ws_kidx   = '0;

  int frames_built  = 0;
  int empty_reports = 0;
  int bytes_taken   = 0;
  int beats_checked = 0;
  int mismatches    = 0;
  int drains        = 0;
  int burst_left    = 0;
  int gap_left      = 0;
  int seg_left      = 0;
  int seg_mode      = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int idle_cycles   = 0;

  frame_beat_t got_beat;
  frame_beat_t want_beat;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Append one complete frame to the outgoing stream
  function automatic void add_frame(input logic [7:0] b0, input bit masked, input int enc,
                                    input logic [63:0] len);
    logic [31:0] key;
    int          n;
    key = $urandom();
    n = int'(len[LenW-1:0]);
    stream_bytes_q.push_back(int'(b0));
    if (enc == ENC_SHORT) begin
      stream_bytes_q.push_back(int'({masked, len[6:0]}));
    end else if (enc == ENC_EXT16) begin
      stream_bytes_q.push_back(int'({masked, LEN_CODE_16}));
      stream_bytes_q.push_back(int'(len[15:8]));
      stream_bytes_q.push_back(int'(len[7:0]));
    end else begin
      stream_bytes_q.push_back(int'({masked, LEN_CODE_64}));
      for (int i = 7; i >= 0; i--) stream_bytes_q.push_back(int'(len[8*i +: 8]));
    end
    if (masked) begin
      for (int i = 3; i >= 0; i--) stream_bytes_q.push_back(int'(key[8*i +: 8]));
    end
    for (int i = 0; i < n; i++) stream_bytes_q.push_back(int'($urandom_range(0, 255)));
    frames_built++;
  endfunction

  function automatic void record_beat(input logic [7:0] pbyte, input logic dvalid,
                                      input logic last);
    frame_beat_t b;
    b.pbyte  = pbyte;
    b.dvalid = dvalid;
    b.op     = ws_op;
    b.masked = ws_masked;
    b.plen   = ws_len;
    b.last   = last;
    unmasked_beats_q.push_back(b);
    if (!dvalid) empty_reports++;
  endfunction

  // Length known: go to the key bytes, report an empty frame, or start payload
  function automatic void close_length();
    ws_kidx = '0;
    if (ws_masked) begin
      ws_phase = PH_KEY;
    end else if (ws_len == '0) begin
      ws_phase = PH_B0;
      record_beat('0, 1'b0, 1'b1);
    end else begin
      ws_remain = ws_len;
      ws_phase  = PH_DATA;
    end
  endfunction

  // Advance the parser by one stream byte and queue any beat it yields
  function automatic void parse_frame_byte(input logic [7:0] b);
    logic [7:0] kb;
    logic       last;
    case (ws_phase)
      PH_B1: begin
        ws_masked = b[7];
        ws_len    = '0;
        if (b[6:0] == LEN_CODE_16) begin
          ws_phase = PH_E16_0;
        end else if (b[6:0] == LEN_CODE_64) begin
          ws_phase = PH_E64_0;
        end else begin
          ws_len = LenW'(b[6:0]);
          close_length();
        end
      end
      PH_E16_0, PH_E16_1, PH_E64_0, PH_E64_1, PH_E64_2, PH_E64_3,
      PH_E64_4, PH_E64_5, PH_E64_6, PH_E64_7: begin
        // Shift in big-endian; the top length bit falls off the end
        ws_len = {ws_len[LenW-9:0], b};
        if (ws_phase == PH_E16_1 || ws_phase == PH_E64_7) close_length();
        else ws_phase = phase_e'(ws_phase + 4'd1);
      end
      PH_KEY: begin
        ws_key  = {ws_key[KeyW-9:0], b};
        ws_kidx = ws_kidx + 2'd1;
        if (ws_kidx == 2'd0) begin
          if (ws_len == '0) begin
            ws_phase = PH_B0;
            record_beat('0, 1'b0, 1'b1);
          end else begin
            ws_remain = ws_len;
            ws_phase  = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        kb        = ws_masked ? ws_key[8*(3-ws_kidx) +: 8] : 8'h00;
        ws_kidx   = ws_kidx + 2'd1;
        ws_remain = ws_remain - 1'b1;
        last      = (ws_remain == '0);
        if (last) ws_phase = PH_B0;
        record_beat(b ^ kb, 1'b1, last);
      end
      default: begin
        ws_op    = b[3:0];
        ws_phase = PH_B1;
      end
    endcase
  endfunction

  function automatic string beat_text(input frame_beat_t b);
    return $sformatf("byte=%02h valid=%0b op=%h masked=%0b len=%0d last=%0b",
                     b.pbyte, b.dvalid, b.op, b.masked, b.plen, b.last);
  endfunction

  // Sender: bursts of bytes with random gaps, pausing at drain marks
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_frame_byte(s_tdata);
        bytes_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (stream_bytes_q.size() != 0 && stream_bytes_q[0] == DRAIN_MARK) begin
          s_tvalid <= 1'b0;
          if (unmasked_beats_q.size() == 0) begin
            void'(stream_bytes_q.pop_front());
            drains++;
          end
        end else if (stream_bytes_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= 8'(stream_bytes_q.pop_front());
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: segments of always-ready, coin-flip and mostly-stalled, plus one long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AT_BYTE) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(10, 120);
      end else begin
        seg_left--;
      end
      case (seg_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Check each output beat against the oldest queued expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      got_beat.pbyte  = m_tdata[ByteW-1:0];
      got_beat.plen   = m_tdata[ByteW +: LenW];
      got_beat.dvalid = m_tuser[0];
      got_beat.op     = m_tuser[4:1];
      got_beat.masked = m_tuser[5];
      got_beat.last   = m_tlast;
      if (unmasked_beats_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected beat %0d: %s", beats_checked, beat_text(got_beat));
      end else begin
        want_beat = unmasked_beats_q.pop_front();
        if (got_beat !== want_beat) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch at beat %0d: expected %s, got %s", beats_checked,
                     beat_text(want_beat), beat_text(got_beat));
        end
      end
      beats_checked++;
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d beats still expected", unmasked_beats_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int          enc;
    bit          masked;
    logic [63:0] len;
    bit          long_done;
    bit          mid_drain;
    long_done = 1'b0;
    mid_drain = 1'b0;

    // Directed frames: empty unmasked, all header flag bits, masked 16-bit length,
    // masked empty frame with the top bit of a 64-bit length set
    add_frame(8'h80, 1'b0, ENC_SHORT, 64'd0);
    add_frame(8'hFF, 1'b0, ENC_SHORT, 64'd1);
    add_frame(8'h02, 1'b1, ENC_EXT16, 64'd1);
    add_frame(8'h7A, 1'b1, ENC_EXT64, 64'h8000_0000_0000_0000);
    stream_bytes_q.push_back(DRAIN_MARK);

    // Random frames: mostly short payloads, a few at the length extremes
    while (stream_bytes_q.size() < STREAM_BYTES) begin
      enc    = $urandom_range(0, 9);
      enc    = (enc < 7) ? ENC_SHORT : (enc < 9) ? ENC_EXT16 : ENC_EXT64;
      masked = $urandom_range(0, 1);
      len    = ($urandom_range(0, 9) == 0) ? 64'd0 : 64'($urandom_range(1, 12));
      if (enc == ENC_SHORT && $urandom_range(0, 29) == 0) len = 64'd125;
      if (enc == ENC_EXT16 && !long_done && stream_bytes_q.size() > 100) begin
        len       = 64'($urandom_range(256, 270));
        long_done = 1'b1;
      end
      if (enc == ENC_EXT64) len[63] = $urandom_range(0, 1);
      add_frame(8'($urandom_range(0, 255)), masked, enc, len);
      if (!mid_drain && stream_bytes_q.size() > 300) begin
        stream_bytes_q.push_back(DRAIN_MARK);
        mid_drain = 1'b1;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stream_bytes_q.size() != 0 || s_tvalid) @(posedge clk_i);
    while (unmasked_beats_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d frames (%0d empty-payload reports) over %0d stream bytes,",
             frames_built, empty_reports, bytes_taken);
    $display("%0d beats checked, one long receiver hold-off and %0d drain pauses.",
             beats_checked, drains);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
